/* hw/rtl/bcgm_pkg.sv */
// ============================================================================
// Border crossing gesture matcher - shared definitions
// Types, sizes and codes used by the classifier, history ring, step checker
// and the top-level sequencer.
// ============================================================================
package bcgm_pkg;

    // Sizes
    localparam int HISTORY_DEPTH = 12;
    localparam int NUM_RULES     = 8;
    localparam int RULE_REGS     = 8;
    localparam int SLOT_W        = 4;
    localparam int SLOT_SUM_W    = SLOT_W + 1;
    localparam int RULE_IDX_W    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CFG_INDEX_W   = 4;
    localparam int LEN_W         = 4;
    localparam int TIME_W        = 32;
    localparam int RULE_W        = 61;
    localparam int MASK_W        = 8;
    localparam int DIFF_W        = 18;
    localparam int COORD_W       = 16;
    localparam int SIZE_W        = 15;

    // Side codes
    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_RIGHT  = 2'd2,
        SIDE_LEFT   = 2'd3
    } side_t;

    // Direction codes
    typedef enum logic {
        DIR_IN  = 1'b0,
        DIR_OUT = 1'b1
    } dir_t;

    // Packed gesture rule, same bit layout as the register
    typedef struct packed {
        logic [TIME_W-1:0] timeout;
        logic              dir;
        logic [LEN_W-1:0]  len;
        logic [23:0]       sides;
    } rule_t;

    // Input request
    typedef struct packed {
        logic signed [COORD_W-1:0] pointer_x;
        logic signed [COORD_W-1:0] pointer_y;
        logic signed [COORD_W-1:0] win_left;
        logic signed [COORD_W-1:0] win_top;
        logic        [SIZE_W-1:0]  win_width;
        logic        [SIZE_W-1:0]  win_height;
        logic                      is_enter;
        logic        [TIME_W-1:0]  event_time;
    } crossing_t;

    // Result request
    typedef struct packed {
        logic [1:0]        crossed_side;
        logic [MASK_W-1:0] matched_rules;
        logic              any_match;
    } result_t;

    // One history ring entry
    typedef struct packed {
        logic              valid;
        logic [1:0]        side;
        logic              dir;
        logic [TIME_W-1:0] stamp;
    } hist_entry_t;

    // Verdict of one walk step
    typedef struct packed {
        logic pass;
        logic last;
    } step_result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECORD,
        ST_RULE,
        ST_WALK,
        ST_FINISH
    } seq_state_t;

endpackage

/* hw/rtl/bcgm_classify.sv */
// ============================================================================
// Crossing side classifier
// Registers the pointer offset from the window center, then picks the side
// by comparing |dy| against |dx|.
// ============================================================================
module bcgm_classify (
    input  logic                clk,
    input  logic                load,
    input  bcgm_pkg::crossing_t crossing,
    output bcgm_pkg::side_t     side
);

    logic signed [bcgm_pkg::DIFF_W-1:0] mid_x;
    logic signed [bcgm_pkg::DIFF_W-1:0] mid_y;
    logic signed [bcgm_pkg::DIFF_W-1:0] dx_reg;
    logic signed [bcgm_pkg::DIFF_W-1:0] dy_reg;
    logic        [bcgm_pkg::DIFF_W-1:0] abs_x;
    logic        [bcgm_pkg::DIFF_W-1:0] abs_y;

    // Window center, half sizes rounded down
    assign mid_x = bcgm_pkg::DIFF_W'(crossing.win_left)
                 + $signed(bcgm_pkg::DIFF_W'(crossing.win_width >> 1));
    assign mid_y = bcgm_pkg::DIFF_W'(crossing.win_top)
                 + $signed(bcgm_pkg::DIFF_W'(crossing.win_height >> 1));

    // Capture the offset when a request is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx_reg <= bcgm_pkg::DIFF_W'(crossing.pointer_x) - mid_x;
            dy_reg <= bcgm_pkg::DIFF_W'(crossing.pointer_y) - mid_y;
        end
    end

    assign abs_x = dx_reg[bcgm_pkg::DIFF_W-1] ? bcgm_pkg::DIFF_W'(-dx_reg)
                                              : bcgm_pkg::DIFF_W'(dx_reg);
    assign abs_y = dy_reg[bcgm_pkg::DIFF_W-1] ? bcgm_pkg::DIFF_W'(-dy_reg)
                                              : bcgm_pkg::DIFF_W'(dy_reg);

    // Zero dx counts as right; steep goes top or bottom, shallow left or right
    always_comb
    begin
        if (dx_reg == '0)
            side = bcgm_pkg::SIDE_RIGHT;
        else if (abs_y > abs_x)
            side = dy_reg[bcgm_pkg::DIFF_W-1] ? bcgm_pkg::SIDE_TOP : bcgm_pkg::SIDE_BOTTOM;
        else
            side = dx_reg[bcgm_pkg::DIFF_W-1] ? bcgm_pkg::SIDE_LEFT : bcgm_pkg::SIDE_RIGHT;
    end

endmodule

/* hw/rtl/bcgm_history.sv */
// ============================================================================
// Crossing history ring
// Holds side, direction and time of the latest crossings; one write port and
// one read port. Entries read as invalid until first written.
// ============================================================================
module bcgm_history (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [bcgm_pkg::SLOT_W-1:0]   wr_slot,
    input  bcgm_pkg::hist_entry_t         wr_entry,
    input  logic [bcgm_pkg::SLOT_W-1:0]   rd_slot,
    output bcgm_pkg::hist_entry_t         rd_entry
);

    logic [bcgm_pkg::HISTORY_DEPTH-1:0] valid_reg;
    logic [1:0]                         side_reg  [bcgm_pkg::HISTORY_DEPTH];
    logic                               dir_reg   [bcgm_pkg::HISTORY_DEPTH];
    logic [bcgm_pkg::TIME_W-1:0]        stamp_reg [bcgm_pkg::HISTORY_DEPTH];

    // Valid bits clear at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[wr_slot] <= wr_entry.valid;
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            side_reg[wr_slot]  <= wr_entry.side;
            dir_reg[wr_slot]   <= wr_entry.dir;
            stamp_reg[wr_slot] <= wr_entry.stamp;
        end
    end

    assign rd_entry.valid = valid_reg[rd_slot];
    assign rd_entry.side  = side_reg[rd_slot];
    assign rd_entry.dir   = dir_reg[rd_slot];
    assign rd_entry.stamp = stamp_reg[rd_slot];

endmodule

/* hw/rtl/bcgm_step_check.sv */
// ============================================================================
// Rule step checker
// Shared compare unit: checks one history entry against one step of a rule
// (side, direction of the oldest step, gap against the timeout).
// ============================================================================
module bcgm_step_check (
    input  bcgm_pkg::rule_t               rule,
    input  logic [bcgm_pkg::LEN_W-1:0]    step,
    input  bcgm_pkg::hist_entry_t         entry,
    input  logic [bcgm_pkg::TIME_W-1:0]   prev_stamp,
    output bcgm_pkg::step_result_t        verdict
);

    logic [1:0]                  want_side;
    logic [bcgm_pkg::TIME_W-1:0] gap;
    logic                        side_ok;
    logic                        dir_ok;
    logic                        gap_ok;
    logic                        first;

    assign first     = (step == '0);
    assign want_side = rule.sides[{step, 1'b0} +: 2];

    // Gap wraps modulo the timestamp width
    assign gap     = entry.stamp - prev_stamp;
    assign side_ok = entry.valid && (entry.side == want_side);
    assign dir_ok  = !first || (entry.dir == rule.dir);
    assign gap_ok  = first || (rule.timeout == '0) || !(rule.timeout < gap);

    assign verdict.pass = side_ok && dir_ok && gap_ok;
    assign verdict.last = ((step + bcgm_pkg::LEN_W'(1)) == rule.len);

endmodule

/* hw/rtl/border_crossing_gesture_matcher.sv */
// ============================================================================
// Border crossing gesture matcher
// Classifies each pointer crossing, records it in a history ring and walks
// every rule over the newest crossings to build the mask of matched rules.
// ----------------------------------------------------------------------------
//   channel   | signals                               | moves
//   crossing  | crossing_valid/ready, crossing        | one pointer crossing
//   result    | result_valid/ready, result            | side and rule mask
//   cfg       | cfg_valid/ready, cfg_index, cfg_data  | one rule register write
//
// Each item is recorded in the history ring, then the shared step checker walks
// each rule over its history slots, oldest first; a walk ends at its first failing
// step or its last step, and a disabled or overlong rule walks none.
// crossing_ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled result holds the next
// item in the finish state until the register frees up.
// Reset clears rules, history valid bits, the write slot and all control.
// ============================================================================
module border_crossing_gesture_matcher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               crossing_valid,
    output logic                               crossing_ready,
    input  bcgm_pkg::crossing_t                crossing,
    output logic                               result_valid,
    input  logic                               result_ready,
    output bcgm_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bcgm_pkg::RULE_W-1:0]        cfg_data
);

    bcgm_pkg::seq_state_t               state_reg, state_next;
    bcgm_pkg::rule_t                    rule_reg [bcgm_pkg::RULE_REGS];
    bcgm_pkg::rule_t                    cur_rule;
    logic [bcgm_pkg::RULE_IDX_W-1:0]    ridx_reg, ridx_next;
    logic [bcgm_pkg::LEN_W-1:0]         step_reg, step_next;
    logic [bcgm_pkg::SLOT_W-1:0]        pos_reg, pos_next;
    logic [bcgm_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [bcgm_pkg::TIME_W-1:0]        prev_reg, prev_next;
    logic [bcgm_pkg::NUM_RULES-1:0]     mask_reg, mask_next;
    logic                               enter_reg;
    logic [bcgm_pkg::TIME_W-1:0]        time_reg;
    logic [1:0]                         side_reg, side_next;
    bcgm_pkg::result_t                  result_reg, result_next;
    logic                               result_valid_reg, result_valid_next;
    logic                               take;
    logic                               hist_wr;
    logic [bcgm_pkg::SLOT_SUM_W-1:0]    start_sum;
    logic [bcgm_pkg::SLOT_W-1:0]        start_slot;
    bcgm_pkg::side_t                    side;
    bcgm_pkg::hist_entry_t              wr_entry;
    bcgm_pkg::hist_entry_t              rd_entry;
    bcgm_pkg::step_result_t             verdict;

    assign take           = crossing_valid && crossing_ready;
    assign crossing_ready = (state_reg == bcgm_pkg::ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign result_valid   = result_valid_reg;
    assign result         = result_reg;
    assign cur_rule       = rule_reg[ridx_reg];

    // Rule registers, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bcgm_pkg::RULE_REGS; i++)
                rule_reg[i] <= '0;
        end
        else if (cfg_valid && (cfg_index < bcgm_pkg::CFG_INDEX_W'(bcgm_pkg::RULE_REGS)))
        begin
            rule_reg[cfg_index[bcgm_pkg::RULE_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Hold the fields the walk needs after the request is taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            enter_reg <= crossing.is_enter;
            time_reg  <= crossing.event_time;
        end
    end

    bcgm_classify u_classify (
        .clk      (clk),
        .load     (take),
        .crossing (crossing),
        .side     (side)
    );

    assign hist_wr        = (state_reg == bcgm_pkg::ST_RECORD);
    assign wr_entry.valid = 1'b1;
    assign wr_entry.side  = side;
    assign wr_entry.dir   = enter_reg ? bcgm_pkg::DIR_IN : bcgm_pkg::DIR_OUT;
    assign wr_entry.stamp = time_reg;

    bcgm_history u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (hist_wr),
        .wr_slot  (slot_reg),
        .wr_entry (wr_entry),
        .rd_slot  (pos_reg),
        .rd_entry (rd_entry)
    );

    bcgm_step_check u_step_check (
        .rule       (cur_rule),
        .step       (step_reg),
        .entry      (rd_entry),
        .prev_stamp (prev_reg),
        .verdict    (verdict)
    );

    // Oldest slot of the current rule's window
    assign start_sum  = bcgm_pkg::SLOT_SUM_W'(slot_reg)
                      + bcgm_pkg::SLOT_SUM_W'(bcgm_pkg::HISTORY_DEPTH + 1)
                      - bcgm_pkg::SLOT_SUM_W'(cur_rule.len);
    assign start_slot = (start_sum >= bcgm_pkg::SLOT_SUM_W'(bcgm_pkg::HISTORY_DEPTH))
                      ? bcgm_pkg::SLOT_W'(start_sum
                                          - bcgm_pkg::SLOT_SUM_W'(bcgm_pkg::HISTORY_DEPTH))
                      : bcgm_pkg::SLOT_W'(start_sum);

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bcgm_pkg::ST_IDLE;
            slot_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        ridx_reg   <= ridx_next;
        step_reg   <= step_next;
        pos_reg    <= pos_next;
        prev_reg   <= prev_next;
        mask_reg   <= mask_next;
        side_reg   <= side_next;
        result_reg <= result_next;
    end

    // Sequencer: record, then walk each rule step by step
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        ridx_next         = ridx_reg;
        step_next         = step_reg;
        pos_next          = pos_reg;
        prev_next         = prev_reg;
        mask_next         = mask_reg;
        side_next         = side_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        // Drop the result once taken
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        unique case (state_reg)
            bcgm_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    mask_next  = '0;
                    ridx_next  = '0;
                    state_next = bcgm_pkg::ST_RECORD;
                end
            end

            bcgm_pkg::ST_RECORD:
            begin
                side_next  = side;
                state_next = bcgm_pkg::ST_RULE;
            end

            bcgm_pkg::ST_RULE:
            begin
                step_next = '0;
                pos_next  = start_slot;
                if ((cur_rule.len != '0)
                    && (cur_rule.len <= bcgm_pkg::LEN_W'(bcgm_pkg::HISTORY_DEPTH)))
                    state_next = bcgm_pkg::ST_WALK;
                else if (ridx_reg == bcgm_pkg::RULE_IDX_W'(bcgm_pkg::NUM_RULES - 1))
                    state_next = bcgm_pkg::ST_FINISH;
                else
                    ridx_next = ridx_reg + bcgm_pkg::RULE_IDX_W'(1);
            end

            bcgm_pkg::ST_WALK:
            begin
                if (verdict.pass && !verdict.last)
                begin
                    step_next = step_reg + bcgm_pkg::LEN_W'(1);
                    prev_next = rd_entry.stamp;
                    pos_next  = (pos_reg == bcgm_pkg::SLOT_W'(bcgm_pkg::HISTORY_DEPTH - 1))
                              ? '0 : pos_reg + bcgm_pkg::SLOT_W'(1);
                end
                else
                begin
                    if (verdict.pass)
                        mask_next[ridx_reg] = 1'b1;
                    if (ridx_reg == bcgm_pkg::RULE_IDX_W'(bcgm_pkg::NUM_RULES - 1))
                        state_next = bcgm_pkg::ST_FINISH;
                    else
                    begin
                        ridx_next  = ridx_reg + bcgm_pkg::RULE_IDX_W'(1);
                        state_next = bcgm_pkg::ST_RULE;
                    end
                end
            end

            bcgm_pkg::ST_FINISH:
            begin
                // Wait for the output register to free up
                if (!result_valid_reg || result_ready)
                begin
                    result_next.crossed_side  = side_reg;
                    result_next.matched_rules = bcgm_pkg::MASK_W'(mask_reg);
                    result_next.any_match     = (mask_reg != '0);
                    result_valid_next         = 1'b1;
                    slot_next  = (slot_reg == bcgm_pkg::SLOT_W'(bcgm_pkg::HISTORY_DEPTH - 1))
                               ? '0 : slot_reg + bcgm_pkg::SLOT_W'(1);
                    state_next = bcgm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bcgm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/bcgm_checker.sv */
// ============================================================================
// Border crossing gesture matcher - port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
module bcgm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                crossing_valid,
    input logic                crossing_ready,
    input logic                result_valid,
    input logic                result_ready,
    input bcgm_pkg::result_t   result
);

    // A taken request keeps crossing_ready low through the record state and the first rule state
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (crossing_valid && crossing_ready) |=> !crossing_ready ##1 !crossing_ready)
        else $error("crossing accepted again too early");

    // The summary flag agrees with the mask
    a_any_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.any_match == (result.matched_rules != '0)))
        else $error("any_match disagrees with matched_rules");

    // With no result pending, no result appears in the cycle right after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (crossing_valid && crossing_ready && !result_valid) |=> !result_valid)
        else $error("result appeared too early");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind border_crossing_gesture_matcher bcgm_checker u_bcgm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .crossing_valid (crossing_valid),
    .crossing_ready (crossing_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
);
